// ===== rtl/core/cartridge_bank_mapper_core_macros.svh =====
// assertion macros shared by the mapper rtl
`ifndef CARTRIDGE_BANK_MAPPER_CORE_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CBM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbm same-cycle check failed");
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbm next-cycle check failed");
`else
`define CBM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/cbm_pkg.sv =====
package cbm_pkg;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int MAX_RAM_BANKS  = 4;

  localparam int ROM_OFF_W  = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
  localparam int ROM_ADDR_W = 21;
  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [7:0] OPEN_BUS  = 8'hFF;
  localparam logic [3:0] RAM_KEY   = 4'hA;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_ROM   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROM_BANK_BITS = 2'd0,
    CFG_RAM_BANKS     = 2'd1,
    CFG_MULTICART     = 2'd2
  } cfg_idx_t;

  // address decode on the top three address bits
  typedef enum logic [2:0] {
    REGION_RAM_EN   = 3'b000,
    REGION_BANK_LO  = 3'b001,
    REGION_BANK_HI  = 3'b010,
    REGION_MODE     = 3'b011,
    REGION_VRAM     = 3'b100,
    REGION_CART_RAM = 3'b101,
    REGION_WRAM     = 3'b110,
    REGION_HIGH     = 3'b111
  } region_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } ram_ctl_t;

endpackage

// ===== rtl/core/cbm_ram.sv =====
module cbm_ram #(
  parameter int NUM_BANKS = 4,
  parameter int ADDR_W    = 15
) (
  input  logic              clk,
  input  cbm_pkg::ram_ctl_t ctl,
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        wdata,
  output logic [7:0]        rdata
);
  import cbm_pkg::*;

  localparam int DEPTH = NUM_BANKS * RAM_BANK_BYTES;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/cartridge_bank_mapper_core.sv =====
// Cartridge bank controller: one bus access per beat, one result beat per access,
// in order. Decode and the cartridge RAM read both happen at the accept edge,
// which also loads the result register, and a new access is taken every cycle
// while the skid is empty; a two-entry output buffer (result register and skid)
// takes one more access during an output stall. Register writes land at the accept
// edge, so the next access already sees them, and cartridge RAM writes and reads
// both happen at the accept edge, so a read right after a write to the same byte
// returns the new value.
// Configuration must be written only while the block is idle; the block itself
// does not enforce this. Cartridge RAM is MAX_RAM_BANKS banks of 8 KiB with no
// reset; reading a byte never written gives an undefined value.
`include "cartridge_bank_mapper_core_macros.svh"

module cartridge_bank_mapper_core #(
  parameter int MAX_RAM_BANKS = cbm_pkg::MAX_RAM_BANKS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cbm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [15:0]                       in_address,
  input  logic [7:0]                        in_write_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cbm_pkg::kind_t                    out_kind,
  output logic [cbm_pkg::ROM_ADDR_W-1:0]    out_rom_address,
  output logic [7:0]                        out_read_data
);
  import cbm_pkg::*;

  localparam int RAM_AW = $clog2(MAX_RAM_BANKS * RAM_BANK_BYTES);
  localparam logic [2:0] MAX_BANKS_C = 3'(MAX_RAM_BANKS);
  localparam logic [ROM_ADDR_W-1:0] ROM_ONE = ROM_ADDR_W'(ROM_BANK_BYTES);

  // configuration
  logic [2:0] rom_bank_bits_r;
  logic [2:0] ram_banks_r;
  logic       multicart_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_bank_bits_r <= 3'd1;
      ram_banks_r     <= 3'd0;
      multicart_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ROM_BANK_BITS: rom_bank_bits_r <= cfg_data;
        CFG_RAM_BANKS:     ram_banks_r     <= cfg_data;
        CFG_MULTICART:     multicart_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective ram bank count as a none flag and a bank mask, plus the rom address and bank masks
  logic [2:0]            ram_n;
  logic                  ram_none;
  logic [RAM_BANK_W-1:0] ram_bmask;
  logic [ROM_ADDR_W-1:0] rom_mask;
  logic [ROM_BANK_W-1:0] bank_mask;

  always_comb begin
    ram_n     = (ram_banks_r > MAX_BANKS_C) ? MAX_BANKS_C : ram_banks_r;
    ram_none  = (ram_n == 3'd0);
    ram_bmask = (ram_n >= 3'd4) ? 2'b11 : ((ram_n >= 3'd2) ? 2'b01 : 2'b00);
    rom_mask  = (ROM_ONE << rom_bank_bits_r) - ROM_ADDR_W'(1);
    bank_mask = (ROM_BANK_W'(1) << rom_bank_bits_r) - ROM_BANK_W'(1);
  end

  // mapper registers
  logic                  ram_en_r, ram_en_nxt;
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [ROM_BANK_W-1:0] rom_high_r, rom_high_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic                  bmode_r, bmode_nxt;

  // pipeline and skid
  logic                  s1_v_r, s1_v_nxt;
  kind_t                 s1_kind_r, s1_kind_nxt;
  logic [ROM_ADDR_W-1:0] s1_rom_r, s1_rom_nxt;
  logic                  s1_hit_r, s1_hit_nxt;
  logic [7:0]            s1_data_r, s1_data_nxt;
  logic                  skid_v_r, skid_v_nxt;
  kind_t                 skid_kind_r;
  logic [ROM_ADDR_W-1:0] skid_rom_r;
  logic [7:0]            skid_data_r;

  logic                  accept;
  logic [2:0]            region;
  logic                  in_ram;
  logic [3:0]            low4;
  logic [4:0]            low5;
  logic [RAM_BANK_W-1:0] bank_wr;
  logic [ROM_BANK_W-1:0] high_wr;
  logic [RAM_BANK_W-1:0] ram_sel;
  logic [RAM_AW-1:0]     ram_addr;
  ram_ctl_t              ram_ctl;
  logic [7:0]            ram_rdata;
  logic [7:0]            s1_out_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_v_r;
  assign region   = in_address[15:13];
  assign in_ram   = (region_t'(region) == REGION_CART_RAM) && ram_en_r && !ram_none;

  always_comb begin
    low4         = (in_write_data[3:0] == 4'd0) ? 4'd1 : in_write_data[3:0];
    low5         = (in_write_data[4:0] == 5'd0) ? 5'd1 : in_write_data[4:0];
    bank_wr      = in_write_data[1:0] & (ram_none ? 2'b11 : ram_bmask);
    high_wr      = multicart_r ? {1'b0, bank_wr, 4'b0} : {bank_wr, 5'b0};
    ram_sel      = bmode_r ? (ram_bank_r & ram_bmask) : '0;
    ram_addr     = RAM_AW'({ram_sel, in_address[RAM_OFF_W-1:0]});

    ram_en_nxt   = ram_en_r;
    rom_bank_nxt = rom_bank_r;
    rom_high_nxt = rom_high_r;
    ram_bank_nxt = ram_bank_r;
    bmode_nxt    = bmode_r;
    ram_ctl      = '0;

    s1_kind_nxt  = KIND_WRITE;
    s1_rom_nxt   = '0;
    s1_hit_nxt   = 1'b0;
    s1_data_nxt  = 8'd0;

    if (in_mode) begin
      unique case (region_t'(region))
        REGION_RAM_EN:  ram_en_nxt = (in_write_data[3:0] == RAM_KEY);
        REGION_BANK_LO: begin
          rom_bank_nxt = multicart_r ? {rom_bank_r[6:4], low4} : {rom_bank_r[6:5], low5};
        end
        REGION_BANK_HI: begin
          ram_bank_nxt = bank_wr;
          rom_high_nxt = high_wr;
          rom_bank_nxt = ((multicart_r ? {3'b0, rom_bank_r[3:0]} : {2'b0, rom_bank_r[4:0]})
                         | high_wr) & bank_mask;
        end
        REGION_MODE:     bmode_nxt  = in_write_data[0];
        REGION_CART_RAM: ram_ctl.wr = in_ram;
        default: ;
      endcase
    end else if (!in_address[15]) begin
      s1_kind_nxt = KIND_ROM;
      if (in_address[14]) begin
        s1_rom_nxt = {rom_bank_r, in_address[ROM_OFF_W-1:0]} & rom_mask;
      end else begin
        s1_rom_nxt = ({rom_high_r, ROM_OFF_W'(0)} & rom_mask & {ROM_ADDR_W{bmode_r}})
                     | ROM_ADDR_W'(in_address[ROM_OFF_W-1:0]);
      end
    end else begin
      s1_kind_nxt = KIND_DATA;
      s1_hit_nxt  = in_ram;
      ram_ctl.rd  = in_ram;
      s1_data_nxt = OPEN_BUS;
    end

    if (!accept) begin
      ram_ctl = '0;
    end
  end

  cbm_ram #(
    .NUM_BANKS (MAX_RAM_BANKS),
    .ADDR_W    (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .ctl   (ram_ctl),
    .addr  (ram_addr),
    .wdata (in_write_data),
    .rdata (ram_rdata)
  );

  assign s1_out_data = s1_hit_r ? ram_rdata : s1_data_r;

  always_comb begin
    skid_v_nxt = skid_v_r;
    s1_v_nxt   = s1_v_r;
    if (skid_v_r) begin
      if (!out_stall) skid_v_nxt = 1'b0;
    end else begin
      if (s1_v_r && out_stall && accept) skid_v_nxt = 1'b1;
      if (!out_stall) s1_v_nxt = 1'b0;
    end
    if (accept) s1_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r   <= 1'b0;
      rom_bank_r <= ROM_BANK_W'(1);
      rom_high_r <= '0;
      ram_bank_r <= '0;
      bmode_r    <= 1'b0;
      s1_v_r     <= 1'b0;
      skid_v_r   <= 1'b0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      skid_v_r <= skid_v_nxt;
      if (accept) begin
        ram_en_r   <= ram_en_nxt;
        rom_bank_r <= rom_bank_nxt;
        rom_high_r <= rom_high_nxt;
        ram_bank_r <= ram_bank_nxt;
        bmode_r    <= bmode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= s1_kind_nxt;
      s1_rom_r  <= s1_rom_nxt;
      s1_hit_r  <= s1_hit_nxt;
      s1_data_r <= s1_data_nxt;
    end
    // older beat parks in the skid while the new one enters
    if (!skid_v_r && s1_v_r && out_stall && accept) begin
      skid_kind_r <= s1_kind_r;
      skid_rom_r  <= s1_rom_r;
      skid_data_r <= s1_out_data;
    end
  end

  assign out_valid       = skid_v_r || s1_v_r;
  assign out_kind        = skid_v_r ? skid_kind_r : s1_kind_r;
  assign out_rom_address = skid_v_r ? skid_rom_r : s1_rom_r;
  assign out_read_data   = skid_v_r ? skid_data_r : s1_out_data;

  `CBM_ASSERT_SAME(a_skid_behind_s1, clk, rst_n, skid_v_r, s1_v_r)
  `CBM_ASSERT_NEXT(a_skid_holds, clk, rst_n, skid_v_r && out_stall, skid_v_r && s1_v_r)
  `CBM_ASSERT_NEXT(a_write_kind, clk, rst_n, accept && in_mode, s1_kind_r == KIND_WRITE)
  `CBM_ASSERT_NEXT(a_rom_low_offset, clk, rst_n, accept && !in_mode && !in_address[15], s1_kind_r == KIND_ROM && s1_rom_r[ROM_OFF_W-1:0] == $past(in_address[ROM_OFF_W-1:0]))

endmodule

// ===== sim/cartridge_bank_mapper_core_test.sv =====
module cartridge_bank_mapper_core_test;
  import cbm_pkg::*;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;
  localparam int RAM_STORE    = MAX_RAM_BANKS * RAM_BANK_BYTES;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 88;
  localparam int TICK_LIMIT   = 400000;

  typedef struct packed {
    kind_t                 kind;
    logic [ROM_ADDR_W-1:0] rom;
    logic [7:0]            rdata;
  } beat_t;

  typedef enum logic [1:0] {STEP_READ, STEP_WRITE, STEP_CONF} step_op_t;

  typedef struct packed {
    step_op_t   op;
    logic [15:0] addr;
    logic [7:0] data;
    logic [2:0] rom_bits;
    logic [2:0] ram_banks;
    logic       multi;
    bit         pinned;
    beat_t      beat;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_mode = 1'b0;
  logic [15:0]           in_address = '0;
  logic [7:0]            in_write_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kind_t                 out_kind;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic [7:0]            out_read_data;

  cartridge_bank_mapper_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_rom_address(out_rom_address),
    .out_read_data  (out_read_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mapper shadow: configuration, bank registers and cartridge ram
  logic [2:0] set_rom_bits = 3'd1;
  logic [2:0] set_ram_banks = 3'd0;
  logic       set_multicart = 1'b0;
  logic       map_ram_on = 1'b0;
  logic [6:0] map_bank = 7'd1;
  logic [6:0] map_bank_hi = 7'd0;
  logic [1:0] map_ram_sel = 2'd0;
  logic       map_mode = 1'b0;
  logic [7:0] cart_bytes [RAM_STORE];
  bit         cart_seen [RAM_STORE];

  beat_t       beats_due [$];
  logic [15:0] ram_spots [$];
  step_t       plan [$];
  int unsigned bad_beats = 0;
  int unsigned beat_no = 0;
  int unsigned ticks = 0;
  bit          sender_jitter = 1'b1;
  bit          stall_on = 1'b1;
  logic [1:0]  stall_left = 2'd0;
  beat_t       head;

  function automatic int unsigned ram_bank_count();
    int unsigned n;
    n = (32'(set_ram_banks) < MAX_RAM_BANKS) ? 32'(set_ram_banks) : MAX_RAM_BANKS;
    if (n >= 4) return 4;
    if (n >= 2) return 2;
    return n;
  endfunction

  function automatic int unsigned rom_span_mask();
    return (32'(ROM_BANK_BYTES) << set_rom_bits) - 1;
  endfunction

  function automatic int unsigned cart_offset(logic [15:0] addr);
    int unsigned off;
    off = 32'(addr) - 'hA000;
    if (map_mode) off += 32'(map_ram_sel) * RAM_BANK_BYTES;
    return off & (ram_bank_count() * RAM_BANK_BYTES - 1);
  endfunction

  function automatic bit ram_unwritten(logic [15:0] addr);
    if (addr < 16'hA000 || addr > 16'hBFFF || !map_ram_on || ram_bank_count() == 0)
      return 1'b0;
    return !cart_seen[cart_offset(addr)];
  endfunction

  // applies one bus access to the shadow and returns the beat it should produce
  function automatic beat_t map_access(logic mode, logic [15:0] addr, logic [7:0] data);
    beat_t       res;
    int unsigned a, cnt, low, tmp, rom;
    bit          hit_ram;
    a = 32'(addr);
    cnt = ram_bank_count();
    res = '0;
    res.kind = KIND_WRITE;
    rom = 0;
    hit_ram = a >= 'hA000 && a <= 'hBFFF && map_ram_on && cnt != 0;
    if (mode == MODE_WRITE) begin
      if (a <= 'h1FFF) begin
        map_ram_on = (data[3:0] == RAM_KEY);
      end else if (a <= 'h3FFF) begin
        // a zero lower bank field still selects bank 1
        low = 32'(data) & (set_multicart ? 'h0F : 'h1F);
        if (low == 0) low = 1;
        tmp = 32'(map_bank) & (set_multicart ? 'hF0 : 'hE0);
        tmp = (tmp | low) & 'h7F;
        map_bank = tmp[6:0];
      end else if (a <= 'h5FFF) begin
        // with no ram the full two bits go to the upper rom bank
        map_ram_sel = data[1:0];
        if (cnt != 0) map_ram_sel = map_ram_sel & 2'(cnt - 1);
        tmp = 32'(map_ram_sel) << (set_multicart ? 4 : 5);
        map_bank_hi = tmp[6:0];
        tmp = (32'(map_bank) & (set_multicart ? 'h0F : 'h1F)) | 32'(map_bank_hi);
        tmp = tmp & ((32'd1 << set_rom_bits) - 1);
        map_bank = tmp[6:0];
      end else if (a <= 'h7FFF) begin
        map_mode = data[0];
      end else if (hit_ram) begin
        cart_bytes[cart_offset(addr)] = data;
        cart_seen[cart_offset(addr)] = 1'b1;
      end
    end else if (a <= 'h3FFF) begin
      res.kind = KIND_ROM;
      rom = a;
      if (map_mode) rom += (32'(map_bank_hi) * ROM_BANK_BYTES) & rom_span_mask();
    end else if (a <= 'h7FFF) begin
      res.kind = KIND_ROM;
      rom = (a - 'h4000 + 32'(map_bank) * ROM_BANK_BYTES) & rom_span_mask();
    end else begin
      res.kind = KIND_DATA;
      res.rdata = hit_ram ? cart_bytes[cart_offset(addr)] : OPEN_BUS;
    end
    res.rom = rom[ROM_ADDR_W-1:0];
    return res;
  endfunction

  function automatic step_t rd(logic [15:0] addr);
    step_t s;
    s = '0;
    s.op = STEP_READ;
    s.addr = addr;
    return s;
  endfunction

  function automatic step_t wr(logic [15:0] addr, logic [7:0] data);
    step_t s;
    s = rd(addr);
    s.op = STEP_WRITE;
    s.data = data;
    return s;
  endfunction

  function automatic step_t pin(step_t s, kind_t kind, logic [ROM_ADDR_W-1:0] rom,
                                logic [7:0] rdata);
    step_t p;
    p = s;
    p.pinned = 1'b1;
    p.beat.kind = kind;
    p.beat.rom = rom;
    p.beat.rdata = rdata;
    return p;
  endfunction

  function automatic step_t conf(logic [2:0] rom_bits, logic [2:0] ram_banks, logic multi);
    step_t s;
    s = '0;
    s.op = STEP_CONF;
    s.rom_bits = rom_bits;
    s.ram_banks = ram_banks;
    s.multi = multi;
    return s;
  endfunction

  // mostly register writes and ram traffic, ram reads aimed at bytes already stored
  function automatic void pick_access(output logic mode, output logic [15:0] addr,
                                      output logic [7:0] data);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    mode = MODE_WRITE;
    data = 8'($urandom);
    addr = 16'h0000;
    if (roll < 8) begin
      addr = 16'($urandom_range('h0000, 'h1FFF));
      if ($urandom_range(0, 9) != 0) data[3:0] = RAM_KEY;
    end else if (roll < 16) begin
      addr = 16'($urandom_range('h2000, 'h3FFF));
    end else if (roll < 23) begin
      addr = 16'($urandom_range('h4000, 'h5FFF));
    end else if (roll < 28) begin
      addr = 16'($urandom_range('h6000, 'h7FFF));
    end else if (roll < 46) begin
      mode = MODE_READ;
      addr = 16'($urandom_range('h0000, 'h7FFF));
    end else if (roll < 64) begin
      addr = 16'($urandom_range('hA000, 'hBFFF));
      ram_spots.push_back(addr);
      if (ram_spots.size() > 16) void'(ram_spots.pop_front());
    end else if (roll < 88) begin
      mode = MODE_READ;
      if (ram_spots.size() != 0 && $urandom_range(0, 4) != 0)
        addr = ram_spots[$urandom_range(0, ram_spots.size() - 1)];
      else
        addr = 16'($urandom_range('hA000, 'hBFFF));
    end else begin
      mode = 1'($urandom);
      addr = 16'($urandom);
    end
    // never read a ram byte that holds nothing yet: store into it instead
    if (mode == MODE_READ && ram_unwritten(addr)) mode = MODE_WRITE;
  endfunction

  task automatic send_access(input logic mode, input logic [15:0] addr,
                             input logic [7:0] data, input bit pinned, input beat_t pinned_beat);
    beat_t want;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_address <= addr;
    in_write_data <= data;
    do @(posedge clk); while (in_stall);
    want = map_access(mode, addr, data);
    if (pinned) want = pinned_beat;
    beats_due.push_back(want);
  endtask

  task automatic pause_sender();
    if (sender_jitter && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [2:0] rom_bits, input logic [2:0] ram_banks,
                             input logic multi);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ROM_BANK_BITS;
    cfg_data <= rom_bits;
    @(posedge clk);
    cfg_index <= CFG_RAM_BANKS;
    cfg_data <= ram_banks;
    @(posedge clk);
    cfg_index <= CFG_MULTICART;
    cfg_data <= {2'b00, multi};
    @(posedge clk);
    cfg_we <= 1'b0;
    set_rom_bits = rom_bits;
    set_ram_banks = ram_banks;
    set_multicart = multi;
  endtask

  // result side backpressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
      stall_left <= 2'd0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 2'd1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= 2'($urandom_range(0, 3));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      beat_no++;
      if (beats_due.size() == 0) begin
        bad_beats++;
        if (bad_beats <= 10)
          $display("beat %0d: nothing outstanding, got kind %0d rom %h data %h",
                   beat_no, out_kind, out_rom_address, out_read_data);
      end else begin
        head = beats_due.pop_front();
        if (out_kind !== head.kind || out_rom_address !== head.rom ||
            out_read_data !== head.rdata) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("beat %0d: expected kind %0d rom %h data %h, got kind %0d rom %h data %h",
                     beat_no, head.kind, head.rom, head.rdata,
                     out_kind, out_rom_address, out_read_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    ticks <= ticks + 1;
    if (ticks == TICK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic        mode;
    logic [15:0] addr;
    logic [7:0]  data;
    beat_t       none;
    int          phase, n;
    bit          calm;
    none = '0;
    plan = '{
      pin(rd(16'h0000), KIND_ROM, 21'h000000, 8'h00),
      pin(rd(16'h3FFF), KIND_ROM, 21'h003FFF, 8'h00),
      pin(rd(16'h4000), KIND_ROM, 21'h004000, 8'h00),
      pin(rd(16'h7FFF), KIND_ROM, 21'h007FFF, 8'h00),
      pin(rd(16'hA000), KIND_DATA, 21'h000000, OPEN_BUS),
      pin(rd(16'hFFFF), KIND_DATA, 21'h000000, OPEN_BUS),
      pin(wr(16'h2000, 8'h00), KIND_WRITE, 21'h000000, 8'h00),
      pin(wr(16'h4000, 8'h03), KIND_WRITE, 21'h000000, 8'h00),
      pin(wr(16'h6000, 8'h01), KIND_WRITE, 21'h000000, 8'h00),
      rd(16'h0000),
      pin(wr(16'hFFFF, 8'hFF), KIND_WRITE, 21'h000000, 8'h00),
      conf(3'd7, 3'd4, 1'b0),
      pin(wr(16'h1FFF, 8'h3A), KIND_WRITE, 21'h000000, 8'h00),
      wr(16'h4000, 8'hFF),
      wr(16'h2000, 8'hFF),
      pin(rd(16'h7FFF), KIND_ROM, 21'h1FFFFF, 8'h00),
      rd(16'h3FFF),
      pin(wr(16'hBFFF, 8'hA5), KIND_WRITE, 21'h000000, 8'h00),
      pin(rd(16'hBFFF), KIND_DATA, 21'h000000, 8'hA5),
      wr(16'hA000, 8'h5A),
      conf(3'd0, 3'd7, 1'b1),
      wr(16'h2000, 8'h10),
      wr(16'h5FFF, 8'hFF),
      rd(16'h4123),
      rd(16'hA000),
      conf(3'd2, 3'd3, 1'b0),
      wr(16'h0000, 8'h00),
      pin(rd(16'hBFFF), KIND_DATA, 21'h000000, OPEN_BUS)
    };
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == STEP_CONF) begin
        load_config(plan[i].rom_bits, plan[i].ram_banks, plan[i].multi);
      end else begin
        send_access(plan[i].op == STEP_WRITE ? MODE_WRITE : MODE_READ, plan[i].addr,
                    plan[i].data, plan[i].pinned, plan[i].beat);
        pause_sender();
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: load_config(3'd7, 3'd4, 1'b0);
        1: load_config(3'd1, 3'd0, 1'b1);
        2: load_config(3'd0, 3'd2, 1'b0);
        3: load_config(3'd3, 3'd1, 1'b1);
        default: load_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                             1'($urandom_range(0, 1)));
      endcase
      // one stretch mid run and the closing stretch run with no idling at all
      calm = (phase == 2 || phase == PHASES - 1);
      sender_jitter = !calm;
      stall_on <= !calm;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick_access(mode, addr, data);
        send_access(mode, addr, data, 1'b0, none);
        pause_sender();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && beats_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
